// ===== hdl/mdt_pkg.sv =====
// shared constants and types for the multi-delimiter tokenizer
package mdt_pkg;

  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 3;
  localparam int PACKED_BYTES = 4;
  localparam int CFG_DATA_W   = PACKED_BYTES * BYTE_W + LEN_W;
  localparam int CFG_IDX_W    = 4;
  localparam int S_TDATA_W    = 8;
  localparam int M_TDATA_W    = 16;
  localparam int KIND_W       = 2;
  localparam int QUEUE_DEPTH  = 2;

  localparam int DEF_MAX_PATTERN_LEN = 4;
  localparam int DEF_NUM_SEPARATORS  = 3;
  localparam int DEF_NUM_REMOVERS    = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_TEXT = 2'd0,
    KIND_SEP  = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

endpackage

// ===== hdl/multi_delimiter_tokenizer.sv =====
// top level: pattern registers, classifying front, queue and tokenizing back
// path: an accepted item passes the front registers and the queue before the back registers its result
// throughput: one item per cycle when it causes at most one result and the output does not stall;
// an item with more results keeps the back busy, as do decisions that emit nothing at a string end
// reset: synchronous, clears patterns, window fill, held-byte valid flag, queue and output
module multi_delimiter_tokenizer #(
  parameter int MAX_PATTERN_LEN = mdt_pkg::DEF_MAX_PATTERN_LEN,
  parameter int NUM_SEPARATORS  = mdt_pkg::DEF_NUM_SEPARATORS,
  parameter int NUM_REMOVERS    = mdt_pkg::DEF_NUM_REMOVERS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mdt_pkg::S_TDATA_W-1:0]   s_tdata,   // in_byte
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mdt_pkg::M_TDATA_W-1:0]   m_tdata,   // out_byte, token_end
  output logic [mdt_pkg::KIND_W-1:0]      m_tuser,   // kind
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [mdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mdt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int NP  = NUM_SEPARATORS + NUM_REMOVERS;
  localparam int IW  = $clog2(NP);
  localparam int CMP = (MAX_PATTERN_LEN < mdt_pkg::PACKED_BYTES) ?
                       MAX_PATTERN_LEN : mdt_pkg::PACKED_BYTES;
  localparam int HW  = NP * CMP;
  localparam int QW  = mdt_pkg::BYTE_W + 1 + HW;

  logic [mdt_pkg::CFG_DATA_W-1:0] pat [NP];
  logic [mdt_pkg::LEN_W-1:0]      pat_len [NP];

  logic                       f_valid;
  logic                       f_ready;
  logic [mdt_pkg::BYTE_W-1:0] f_byte;
  logic                       f_last;
  logic [HW-1:0]              f_hits;

  logic                       q_valid;
  logic                       q_pop;
  logic [QW-1:0]              q_data;

  logic [mdt_pkg::BYTE_W-1:0] out_byte;
  mdt_pkg::kind_t             out_kind;
  logic                       out_end;

  // separators first, then removers, in register index order
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NP; p++) begin
        pat[p] <= '0;
      end
    end else if (cfg_we && cfg_index < mdt_pkg::CFG_IDX_W'(NP)) begin
      pat[cfg_index[IW-1:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      pat_len[p] = pat[p][mdt_pkg::PACKED_BYTES*mdt_pkg::BYTE_W +: mdt_pkg::LEN_W];
    end
  end

  mdt_front #(
    .M  (MAX_PATTERN_LEN),
    .NS (NUM_SEPARATORS),
    .NR (NUM_REMOVERS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .pat      (pat),
    .f_valid  (f_valid),
    .f_ready  (f_ready),
    .f_byte   (f_byte),
    .f_last   (f_last),
    .f_hits   (f_hits)
  );

  mdt_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_hits, f_last, f_byte}),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_data  (q_data)
  );

  mdt_back #(
    .M  (MAX_PATTERN_LEN),
    .NS (NUM_SEPARATORS),
    .NR (NUM_REMOVERS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_byte    (q_data[mdt_pkg::BYTE_W-1:0]),
    .q_last    (q_data[mdt_pkg::BYTE_W]),
    .q_hits    (q_data[QW-1:mdt_pkg::BYTE_W+1]),
    .pat_len   (pat_len),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_end   (out_end),
    .out_last  (m_tlast)
  );

  assign m_tdata = {{(mdt_pkg::M_TDATA_W - mdt_pkg::BYTE_W - 1){1'b0}}, out_end, out_byte};
  assign m_tuser = out_kind;

endmodule

// ===== hdl/mdt_front.sv =====
// front stage: takes input items and compares each byte against every pattern byte
module mdt_front #(
  parameter int M  = mdt_pkg::DEF_MAX_PATTERN_LEN,
  parameter int NS = mdt_pkg::DEF_NUM_SEPARATORS,
  parameter int NR = mdt_pkg::DEF_NUM_REMOVERS,
  localparam int NP  = NS + NR,
  localparam int CMP = (M < mdt_pkg::PACKED_BYTES) ? M : mdt_pkg::PACKED_BYTES,
  localparam int HW  = NP * CMP
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mdt_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          s_tlast,
  input  logic [mdt_pkg::CFG_DATA_W-1:0] pat [NP],
  output logic                          f_valid,
  input  logic                          f_ready,
  output logic [mdt_pkg::BYTE_W-1:0]    f_byte,
  output logic                          f_last,
  output logic [HW-1:0]                 f_hits
);

  logic          accept;
  logic [HW-1:0] hits;

  assign s_tready = !f_valid || f_ready;
  assign accept   = s_tvalid && s_tready;

  // per pattern and position: does this byte equal that pattern byte
  always_comb begin
    for (int p = 0; p < NP; p++) begin
      for (int i = 0; i < CMP; i++) begin
        hits[p*CMP + i] = (s_tdata[mdt_pkg::BYTE_W-1:0] ==
                           pat[p][i*mdt_pkg::BYTE_W +: mdt_pkg::BYTE_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (f_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_byte <= s_tdata[mdt_pkg::BYTE_W-1:0];
      f_last <= s_tlast;
      f_hits <= hits;
    end
  end

endmodule

// ===== hdl/mdt_queue.sv =====
// short fifo between the classifying front and the tokenizing back
module mdt_queue #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_pop,
  output logic [W-1:0] out_data
);

  localparam int PW = $clog2(mdt_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(mdt_pkg::QUEUE_DEPTH + 1);

  logic [W-1:0]  entry [mdt_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != CW'(mdt_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entry[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(mdt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(mdt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_data;
    end
  end

endmodule

// ===== hdl/mdt_back.sv =====
// back stage: lookahead window, pattern decisions, one result per cycle unless stalled
module mdt_back #(
  parameter int M  = mdt_pkg::DEF_MAX_PATTERN_LEN,
  parameter int NS = mdt_pkg::DEF_NUM_SEPARATORS,
  parameter int NR = mdt_pkg::DEF_NUM_REMOVERS,
  localparam int NP  = NS + NR,
  localparam int CMP = (M < mdt_pkg::PACKED_BYTES) ? M : mdt_pkg::PACKED_BYTES,
  localparam int HW  = NP * CMP
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  logic [mdt_pkg::BYTE_W-1:0]      q_byte,
  input  logic                            q_last,
  input  logic [HW-1:0]                   q_hits,
  input  logic [mdt_pkg::LEN_W-1:0]       pat_len [NP],
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [mdt_pkg::BYTE_W-1:0]      out_byte,
  output mdt_pkg::kind_t                  out_kind,
  output logic                            out_end,
  output logic                            out_last
);

  localparam int FW = $clog2(M + 1);
  localparam int CW = 4;

  // window and token state
  logic [mdt_pkg::BYTE_W-1:0] win_b [M];
  logic [HW-1:0]              win_h [M];
  logic [FW-1:0]              fill;
  logic [mdt_pkg::BYTE_W-1:0] held_byte;
  logic                       held_valid;
  logic [mdt_pkg::LEN_W-1:0]  sep_rem;
  logic                       busy;
  logic                       last_mode;

  logic [mdt_pkg::BYTE_W-1:0] win_b_next [M];
  logic [HW-1:0]              win_h_next [M];
  logic [FW-1:0]              fill_next;
  logic [mdt_pkg::BYTE_W-1:0] held_byte_next;
  logic                       held_valid_next;
  logic [mdt_pkg::LEN_W-1:0]  sep_rem_next;
  logic                       busy_next;

  logic                       adv;
  logic                       load;
  logic [mdt_pkg::BYTE_W-1:0] eff_b [M];
  logic [HW-1:0]              eff_h [M];
  logic [FW-1:0]              eff_fill;
  logic                       lmode;
  logic [NP-1:0]              hit;
  logic                       rem_hit;
  logic [mdt_pkg::LEN_W-1:0]  rem_len;
  logic                       sep_hit;
  logic [mdt_pkg::LEN_W-1:0]  sep_len;
  logic [mdt_pkg::LEN_W-1:0]  drop;
  logic                       done;
  logic                       em;
  logic [mdt_pkg::BYTE_W-1:0] em_byte;
  mdt_pkg::kind_t             em_kind;
  logic                       em_end;

  assign adv   = !out_valid || out_ready;
  assign load  = adv && !busy && q_valid;
  assign q_pop = load;

  // window as seen this cycle, with the incoming byte appended
  always_comb begin
    for (int i = 0; i < M; i++) begin
      eff_b[i] = win_b[i];
      eff_h[i] = win_h[i];
      if (load && fill == FW'(i)) begin
        eff_b[i] = q_byte;
        eff_h[i] = q_hits;
      end
    end
    eff_fill = load ? fill + FW'(1) : fill;
    lmode    = load ? q_last : last_mode;
  end

  // pattern matching at the window head
  always_comb begin
    logic bytes_ok;
    for (int p = 0; p < NP; p++) begin
      bytes_ok = 1'b1;
      for (int i = 0; i < CMP; i++) begin
        if (CW'(i) < CW'(pat_len[p]) && !eff_h[i][p*CMP + i]) begin
          bytes_ok = 1'b0;
        end
      end
      hit[p] = (pat_len[p] != '0) && (CW'(pat_len[p]) <= CW'(CMP)) &&
               (CW'(pat_len[p]) <= CW'(eff_fill)) && bytes_ok;
    end
    sep_hit = 1'b0;
    sep_len = '0;
    for (int p = NS - 1; p >= 0; p--) begin
      if (hit[p]) begin
        sep_hit = 1'b1;
        sep_len = pat_len[p];
      end
    end
    rem_hit = 1'b0;
    rem_len = '0;
    for (int p = NP - 1; p >= NS; p--) begin
      if (hit[p]) begin
        rem_hit = 1'b1;
        rem_len = pat_len[p];
      end
    end
  end

  // one action per cycle unless the output is stalled
  always_comb begin
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    sep_rem_next    = sep_rem;
    drop            = '0;
    done            = 1'b0;
    em              = 1'b0;
    em_byte         = held_byte;
    em_kind         = mdt_pkg::KIND_TEXT;
    em_end          = 1'b0;
    if (busy || load) begin
      if (sep_rem != '0) begin
        em           = 1'b1;
        em_byte      = eff_b[0];
        em_kind      = mdt_pkg::KIND_SEP;
        em_end       = (sep_rem == mdt_pkg::LEN_W'(1));
        drop         = mdt_pkg::LEN_W'(1);
        sep_rem_next = sep_rem - mdt_pkg::LEN_W'(1);
        done         = !lmode && (sep_rem == mdt_pkg::LEN_W'(1));
      end else if (lmode && eff_fill == '0) begin
        em     = 1'b1;
        em_end = 1'b1;
        if (held_valid) begin
          held_valid_next = 1'b0;
        end else begin
          em_byte = '0;
          em_kind = mdt_pkg::KIND_END;
          done    = 1'b1;
        end
      end else if (!lmode && load && eff_fill != FW'(M)) begin
        done = 1'b1;
      end else if (rem_hit) begin
        em              = held_valid;
        em_end          = 1'b1;
        held_valid_next = 1'b0;
        drop            = rem_len;
        done            = !lmode;
      end else if (sep_hit) begin
        em     = 1'b1;
        em_end = 1'b1;
        if (held_valid) begin
          held_valid_next = 1'b0;
        end else begin
          em_byte      = eff_b[0];
          em_kind      = mdt_pkg::KIND_SEP;
          em_end       = (sep_len == mdt_pkg::LEN_W'(1));
          drop         = mdt_pkg::LEN_W'(1);
          sep_rem_next = sep_len - mdt_pkg::LEN_W'(1);
          done         = !lmode && (sep_len == mdt_pkg::LEN_W'(1));
        end
      end else begin
        em              = held_valid;
        held_byte_next  = eff_b[0];
        held_valid_next = 1'b1;
        drop            = mdt_pkg::LEN_W'(1);
        done            = !lmode;
      end
    end
    busy_next = (busy || load) ? !done : busy;
  end

  // drop consumed bytes from the window head
  always_comb begin
    for (int i = 0; i < M; i++) begin
      win_b_next[i] = eff_b[i];
      win_h_next[i] = eff_h[i];
    end
    for (int j = 1; j <= CMP; j++) begin
      if (drop == mdt_pkg::LEN_W'(j)) begin
        for (int i = 0; i + j < M; i++) begin
          win_b_next[i] = eff_b[i + j];
          win_h_next[i] = eff_h[i + j];
        end
      end
    end
    fill_next = eff_fill - FW'(drop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      held_valid <= 1'b0;
      sep_rem    <= '0;
      busy       <= 1'b0;
      last_mode  <= 1'b0;
      out_valid  <= 1'b0;
    end else if (adv) begin
      fill       <= fill_next;
      held_valid <= held_valid_next;
      sep_rem    <= sep_rem_next;
      busy       <= busy_next;
      last_mode  <= lmode;
      out_valid  <= em;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < M; i++) begin
        win_b[i] <= win_b_next[i];
        win_h[i] <= win_h_next[i];
      end
      held_byte <= held_byte_next;
      out_byte  <= em_byte;
      out_kind  <= em_kind;
      out_end   <= em_end;
      out_last  <= done;
    end
  end

endmodule
